FILE: design/npsl_pkg.sv
// Package for the node pool block: sizes, mode and status codes, controller states, command and status structs.
// No dependencies.
package npsl_pkg;

    localparam int NODES_DEF = 16;
    localparam int KEY_BITS_DEF = 16;

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_COLLECT = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_WALK,
        S_DEL_WALK,
        S_MARK,
        S_SWEEP,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic decode;
        logic ins_step;
        logic del_step;
        logic mark_step;
        logic sweep_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic is_collect;
        logic decode_done;
        logic walk_done;
        logic mark_done;
        logic sweep_done;
    } stat_t;

endpackage

FILE: design/node_pool_sorted_lists_mark_sweep_top.sv
// Node pool with two sorted lists, a free list and mark and sweep collection.
// A result is registered after the decode step when the first node settles the operation,
// else after the list walk; a collection runs a mark walk over the three lists and a sweep.
// Throughput is set by the single list walker: one word at a time. A word is taken once
// the controller is idle; its result waits until the previous one has been delivered.
// Reset is synchronous, active low, and restores the pool to its initial free list at once.
module node_pool_sorted_lists_mark_sweep_top #(
    parameter int NODES    = npsl_pkg::NODES_DEF,
    parameter int KEY_BITS = npsl_pkg::KEY_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic                     s_list_select,
    input  logic signed [15:0]       s_key_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic [$clog2(NODES):0]   m_node_index,
    output logic [$clog2(NODES):0]   m_reclaimed_count
);
    import npsl_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  idle, in_fire;
    logic  m_valid_reg;
    logic [1:0] res_status;
    logic [$clog2(NODES):0] res_index, res_count;
    logic [1:0] status_reg;
    logic [$clog2(NODES):0] index_reg, count_reg;

    assign s_ready = idle;
    assign in_fire = s_valid && s_ready;

    npsl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_busy(m_valid_reg && !m_ready), .stat(stat), .cmd(cmd), .idle(idle)
    );

    npsl_dp #(.NODES(NODES), .KEY_BITS(KEY_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .in_mode(s_mode), .in_list(s_list_select), .in_key(s_key_value),
        .stat(stat), .res_status(res_status), .res_index(res_index),
        .res_count(res_count)
    );

    // Output register for the result word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
                status_reg  <= res_status;
                index_reg   <= res_index;
                count_reg   <= res_count;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_status = status_reg;
    assign m_node_index = index_reg;
    assign m_reclaimed_count = count_reg;

endmodule

FILE: design/npsl_ctrl.sv
// Controller state machine for the node pool block.
// Depends on npsl_pkg.
module npsl_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            out_busy,
    input  npsl_pkg::stat_t stat,
    output npsl_pkg::cmd_t  cmd,
    output logic            idle
);
    import npsl_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (stat.decode_done) state_next = S_DONE;
                else if (stat.is_insert) state_next = S_INS_WALK;
                else if (stat.is_delete) state_next = S_DEL_WALK;
                else state_next = S_MARK;
            end
            S_INS_WALK, S_DEL_WALK: begin
                if (stat.walk_done) state_next = S_DONE;
            end
            S_MARK: begin
                if (stat.mark_done) state_next = S_SWEEP;
            end
            S_SWEEP: begin
                if (stat.sweep_done) state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_busy) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd = '0;
        idle = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                idle = 1'b1;
                cmd.start = in_fire;
            end
            S_DECODE:   cmd.decode = 1'b1;
            S_INS_WALK: cmd.ins_step = 1'b1;
            S_DEL_WALK: cmd.del_step = 1'b1;
            S_MARK:     cmd.mark_step = 1'b1;
            S_SWEEP:    cmd.sweep_step = 1'b1;
            S_DONE:     cmd.finish = !out_busy;
            default:    cmd = '0;
        endcase
    end

endmodule

FILE: design/npsl_dp.sv
// Datapath for the node pool block: key and link stores, marks, heads, walkers.
// Depends on npsl_pkg.
module npsl_dp #(
    parameter int NODES    = npsl_pkg::NODES_DEF,
    parameter int KEY_BITS = npsl_pkg::KEY_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  npsl_pkg::cmd_t           cmd,
    input  logic [1:0]               in_mode,
    input  logic                     in_list,
    input  logic signed [15:0]       in_key,
    output npsl_pkg::stat_t          stat,
    output logic [1:0]               res_status,
    output logic [$clog2(NODES):0]   res_index,
    output logic [$clog2(NODES):0]   res_count
);
    import npsl_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int PW = IW + 1;
    localparam logic [PW-1:0] NIL = PW'(NODES);

    // Pool stores; small enough for flip-flops read through multiplexers.
    logic signed [KEY_BITS-1:0] keys_reg [NODES];
    logic [PW-1:0]              links_reg [NODES];
    logic [NODES-1:0]           marks_reg;
    logic [PW-1:0] head0_reg, head1_reg, free_reg;

    logic [1:0]    mode_reg;
    logic          sel_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [PW-1:0] prev_reg, cur_reg, tnode_reg;
    logic [PW-1:0] steps_reg;
    logic [1:0]    pass_reg;
    logic [1:0]    status_reg;
    logic [PW-1:0] index_reg, count_reg;

    logic signed [KEY_BITS-1:0] key_ext;
    logic [PW-1:0] head_sel, free_next_link, cur_next, prev_link, head_link;
    logic cur_nil;

    function automatic logic [PW-1:0] nil_fix(input logic [PW-1:0] v);
        nil_fix = (v >= NIL) ? NIL : v;
    endfunction

    assign key_ext  = KEY_BITS'(in_key);
    assign head_sel = sel_reg ? head1_reg : head0_reg;
    assign free_next_link = (free_reg < NIL) ? nil_fix(links_reg[free_reg[IW-1:0]]) : NIL;
    assign cur_nil  = (cur_reg >= NIL);
    assign cur_next = cur_nil ? NIL : nil_fix(links_reg[cur_reg[IW-1:0]]);
    assign prev_link = (prev_reg < NIL) ? nil_fix(links_reg[prev_reg[IW-1:0]]) : NIL;
    assign head_link = (head_sel < NIL) ? nil_fix(links_reg[head_sel[IW-1:0]]) : NIL;

    // Status back to the controller.
    always_comb begin
        stat = '0;
        stat.is_insert  = (mode_reg == MODE_INSERT);
        stat.is_delete  = (mode_reg == MODE_DELETE);
        stat.is_collect = (mode_reg == MODE_COLLECT);
        stat.decode_done = (mode_reg == MODE_NONE)
            || (mode_reg == MODE_INSERT && (free_reg >= NIL || head_sel >= NIL
                || key_reg < keys_reg[head_sel[IW-1:0]]))
            || (mode_reg == MODE_DELETE && (head_sel >= NIL
                || keys_reg[head_sel[IW-1:0]] == key_reg));
        stat.walk_done = cur_nil || steps_reg >= NIL
            || (mode_reg == MODE_INSERT && !(key_reg > keys_reg[cur_reg[IW-1:0]]))
            || (mode_reg == MODE_DELETE && keys_reg[cur_reg[IW-1:0]] == key_reg);
        stat.mark_done  = (pass_reg == 2'd2) && (cur_nil || steps_reg >= NIL);
        stat.sweep_done = (steps_reg == NIL - PW'(1));
    end

    // Head writes go to the selected list.
    task automatic set_head(input logic [PW-1:0] v);
        if (sel_reg) head1_reg <= v;
        else head0_reg <= v;
    endtask

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++) begin
                keys_reg[i]  <= '0;
                links_reg[i] <= PW'(i + 1);
            end
            marks_reg <= '0;
            head0_reg <= NIL;
            head1_reg <= NIL;
            free_reg  <= '0;
        end else begin
            if (cmd.start) begin
                mode_reg   <= in_mode;
                sel_reg    <= in_list;
                key_reg    <= key_ext;
                status_reg <= ST_OK;
                index_reg  <= NIL;
                count_reg  <= '0;
                steps_reg  <= '0;
                pass_reg   <= '0;
            end
            // First step of every operation.
            if (cmd.decode) begin
                unique case (mode_reg)
                    MODE_INSERT: begin
                        if (free_reg >= NIL) begin
                            status_reg <= ST_NO_FREE;
                        end else begin
                            free_reg  <= free_next_link;
                            keys_reg[free_reg[IW-1:0]] <= key_reg;
                            index_reg <= free_reg;
                            tnode_reg <= free_reg;
                            if (head_sel >= NIL) begin
                                links_reg[free_reg[IW-1:0]] <= NIL;
                                set_head(free_reg);
                            end else if (key_reg < keys_reg[head_sel[IW-1:0]]) begin
                                links_reg[free_reg[IW-1:0]] <= head_sel;
                                set_head(free_reg);
                            end else begin
                                links_reg[free_reg[IW-1:0]] <= NIL;
                                prev_reg <= head_sel;
                                cur_reg  <= (head_link == free_reg) ? NIL : head_link;
                            end
                        end
                    end
                    MODE_DELETE: begin
                        if (head_sel >= NIL) begin
                            status_reg <= ST_EMPTY;
                        end else if (keys_reg[head_sel[IW-1:0]] == key_reg) begin
                            index_reg <= head_sel;
                            set_head(head_link);
                        end else begin
                            prev_reg <= head_sel;
                            cur_reg  <= head_link;
                        end
                    end
                    MODE_COLLECT: begin
                        cur_reg <= head0_reg;
                    end
                    default: ;
                endcase
            end
            // One node of the insert walk per cycle.
            if (cmd.ins_step) begin
                steps_reg <= steps_reg + PW'(1);
                if (cur_nil || steps_reg >= NIL) begin
                    links_reg[prev_reg[IW-1:0]] <= tnode_reg;
                end else if (!(key_reg > keys_reg[cur_reg[IW-1:0]])) begin
                    links_reg[tnode_reg[IW-1:0]] <= cur_reg;
                    links_reg[prev_reg[IW-1:0]]  <= tnode_reg;
                end else begin
                    prev_reg <= cur_reg;
                    cur_reg  <= cur_next;
                end
            end
            // One node of the delete walk per cycle.
            if (cmd.del_step) begin
                steps_reg <= steps_reg + PW'(1);
                if (cur_nil || steps_reg >= NIL) begin
                    status_reg <= ST_NOTFOUND;
                end else if (keys_reg[cur_reg[IW-1:0]] == key_reg) begin
                    index_reg <= cur_reg;
                    links_reg[prev_reg[IW-1:0]] <= cur_next;
                end else begin
                    prev_reg <= cur_reg;
                    cur_reg  <= cur_next;
                end
            end
            // Mark walk over the three lists in turn.
            if (cmd.mark_step) begin
                if (cur_nil || steps_reg >= NIL) begin
                    pass_reg  <= pass_reg + 2'd1;
                    steps_reg <= '0;
                    cur_reg   <= (pass_reg == 2'd0) ? head1_reg : free_reg;
                end else begin
                    marks_reg[cur_reg[IW-1:0]] <= 1'b1;
                    cur_reg   <= cur_next;
                    steps_reg <= steps_reg + PW'(1);
                end
            end
            // Sweep one index per cycle, ascending; marks are cleared as they go.
            if (cmd.sweep_step) begin
                steps_reg <= steps_reg + PW'(1);
                if (!marks_reg[steps_reg[IW-1:0]]) begin
                    links_reg[steps_reg[IW-1:0]] <= free_reg;
                    keys_reg[steps_reg[IW-1:0]]  <= '0;
                    free_reg  <= steps_reg;
                    count_reg <= count_reg + PW'(1);
                end
                marks_reg[steps_reg[IW-1:0]] <= 1'b0;
            end
        end
    end

    assign res_status = status_reg;
    assign res_index  = index_reg;
    assign res_count  = count_reg;

endmodule

FILE: design/npsl_checker.sv
// Port-level checker for the node pool block, bound to the top level.
// Depends on the top level's ports only.
module npsl_checker #(
    parameter int NODES = 16
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [1:0]             m_status,
    input logic [$clog2(NODES):0] m_node_index,
    input logic [$clog2(NODES):0] m_reclaimed_count
);
    // Only one word is in progress: after an acceptance the input is closed.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("word accepted while busy");

    // A result word never appears the cycle after a word is accepted, unless an earlier result is still held.
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (!m_valid || m_ready)) |=> !m_valid)
        else $error("result too early");

    // A failed operation reports no node.
    a_fail_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != 2'd0) |-> (m_node_index == ($clog2(NODES)+1)'(NODES)))
        else $error("node reported on failure");

    // Reclaimed count never exceeds the pool size.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reclaimed_count <= ($clog2(NODES)+1)'(NODES)))
        else $error("reclaimed count out of range");

    // A pending result holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_node_index)))
        else $error("result dropped");
endmodule

bind node_pool_sorted_lists_mark_sweep_top npsl_checker #(.NODES(NODES)) u_npsl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_node_index(m_node_index), .m_reclaimed_count(m_reclaimed_count)
);
